>>> rtl/lfs_pkg.sv
`timescale 1ns / 1ps
package lfs_pkg;

  // Command specifiers and fixed frame bytes
  localparam logic [7:0] CS_IDENTIFY    = 8'h81;
  localparam logic [7:0] BIT_CHECK_NONE = 8'h80;
  localparam logic [7:0] CS_IDENT_REPLY = 8'h4F;
  localparam logic [7:0] CS_ASSIGN      = 8'h11;
  localparam logic [7:0] CS_STORE       = 8'h17;
  localparam logic [7:0] CS_SWITCH_WAIT = 8'h04;
  localparam logic [7:0] ERR_NONE       = 8'h00;

  localparam int unsigned COB_W        = 11;
  localparam int unsigned NODE_W       = 7;
  localparam int unsigned PROBE_W      = 5;
  localparam int unsigned PART_W       = 2;
  localparam int unsigned VALUE_W      = 32;
  localparam logic [PART_W-1:0]  PART_LAST  = 2'd3;
  localparam logic [PROBE_W-1:0] PROBE_LAST = 5'd31;
  localparam logic [PROBE_W-1:0] POS_LAST_NEXT = 5'd1;

  localparam logic [COB_W-1:0] MASTER_COB_RST = 11'd2021;
  localparam logic [COB_W-1:0] SLAVE_COB_RST  = 11'd2020;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic REG_MASTER_COB = 1'b0;
  localparam logic REG_SLAVE_COB  = 1'b1;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned OUT_USER_W = 3;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_FRAME = 2'd1,
    REQ_WEND  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_IDENT  = 5'b00010,
    PH_PROBE  = 5'b00100,
    PH_ASSIGN = 5'b01000,
    PH_STORE  = 5'b10000
  } phase_t;

  typedef struct packed {
    req_t              kind;
    logic [NODE_W-1:0] node_id;
    logic              ident_ok;
    logic              assign_ok;
    logic              store_ok;
  } lfs_cmd_t;

  typedef struct packed {
    logic            tx_valid;
    logic [7:0][7:0] bytes;
    logic            done;
    logic            success;
  } lfs_res_t;

endpackage

>>> rtl/lfs_front.sv
`timescale 1ns / 1ps
module lfs_front (
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lfs_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [lfs_pkg::IN_USER_W-1:0]    in_tuser,
  input  logic [lfs_pkg::COB_W-1:0]        slave_cob_id,
  input  logic                             q_full,
  output logic                             q_push,
  output lfs_pkg::lfs_cmd_t                q_cmd
);
  import lfs_pkg::*;

  logic [NODE_W-1:0] node_id;
  logic [COB_W-1:0]  rx_can_id;
  logic [7:0]        rx_byte0;
  logic [7:0]        rx_byte1;
  req_t              kind;

  assign node_id   = in_tdata[6:0];
  assign rx_can_id = in_tdata[17:7];
  assign rx_byte0  = in_tdata[25:18];
  assign rx_byte1  = in_tdata[33:26];
  assign kind      = req_t'(in_tuser);

  assign in_tready = !q_full;
  // drop the unused request code here, it never reaches the sequencer
  assign q_push    = in_tvalid && !q_full && (kind != REQ_NONE);

  always_comb begin
    q_cmd           = '0;
    q_cmd.kind      = kind;
    q_cmd.node_id   = node_id;
    q_cmd.ident_ok  = (rx_can_id == slave_cob_id) && (rx_byte0 == CS_IDENT_REPLY);
    q_cmd.assign_ok = (rx_byte0 == CS_ASSIGN) && (rx_byte1 == ERR_NONE);
    q_cmd.store_ok  = (rx_byte0 == CS_STORE) && (rx_byte1 == ERR_NONE);
  end

endmodule

>>> rtl/lfs_queue.sv
`timescale 1ns / 1ps
module lfs_queue #(
  parameter int unsigned DEPTH = lfs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lfs_pkg::lfs_cmd_t push_cmd,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output lfs_pkg::lfs_cmd_t head_cmd
);
  import lfs_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  lfs_cmd_t        mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full     = (count_r == CNT_FULL);
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> rtl/lfs_back.sv
`timescale 1ns / 1ps
module lfs_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  lfs_pkg::lfs_cmd_t q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output lfs_pkg::lfs_res_t out_res
);
  import lfs_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [PROBE_W-1:0]  probe_index_r, probe_index_nxt;
  logic [PART_W-1:0]   part_sub_r, part_sub_nxt;
  logic [PART_W-1:0]   part_next_r, part_next_nxt;
  logic [VALUE_W-1:0]  part_value_r, part_value_nxt;
  logic                frame_seen_r, frame_seen_nxt;
  logic                last_frame_ok_r, last_frame_ok_nxt;
  logic [NODE_W-1:0]   assign_id_r, assign_id_nxt;
  logic                out_valid_r, out_valid_nxt;
  lfs_res_t            res_r, res_nxt;

  logic                take;
  logic                has_res;
  logic                send_probe;
  logic [PROBE_W-1:0]  pos;

  // advance whenever the output register is free or being emptied
  assign take      = !q_empty && (!out_valid_r || out_ready);
  assign q_pop     = take;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;
  assign pos       = ~probe_index_r;

  always_comb begin
    phase_nxt         = phase_r;
    probe_index_nxt   = probe_index_r;
    part_sub_nxt      = part_sub_r;
    part_next_nxt     = part_next_r;
    part_value_nxt    = part_value_r;
    frame_seen_nxt    = frame_seen_r;
    last_frame_ok_nxt = last_frame_ok_r;
    assign_id_nxt     = assign_id_r;
    has_res           = 1'b0;
    send_probe        = 1'b0;
    res_nxt           = '0;

    if (take) begin
      if (q_cmd.kind == REQ_START) begin
        assign_id_nxt     = q_cmd.node_id;
        probe_index_nxt   = '0;
        part_sub_nxt      = '0;
        part_next_nxt     = '0;
        part_value_nxt    = '0;
        last_frame_ok_nxt = 1'b0;
        frame_seen_nxt    = 1'b0;
        phase_nxt         = PH_IDENT;
        has_res           = 1'b1;
        res_nxt.tx_valid  = 1'b1;
        res_nxt.bytes[0]  = CS_IDENTIFY;
        res_nxt.bytes[5]  = BIT_CHECK_NONE;
      end else if (phase_r != PH_IDLE) begin
        has_res = 1'b1;
        if (q_cmd.kind == REQ_FRAME) begin
          case (phase_r)
            PH_IDENT: begin
              has_res           = 1'b0;
              frame_seen_nxt    = 1'b1;
              last_frame_ok_nxt = q_cmd.ident_ok;
            end
            PH_PROBE: begin
              has_res        = 1'b0;
              frame_seen_nxt = 1'b1;
            end
            PH_ASSIGN: begin
              if (q_cmd.assign_ok) begin
                phase_nxt        = PH_STORE;
                frame_seen_nxt   = 1'b0;
                res_nxt.tx_valid = 1'b1;
                res_nxt.bytes[0] = CS_STORE;
              end else begin
                phase_nxt    = PH_IDLE;
                res_nxt.done = 1'b1;
              end
            end
            default: begin
              phase_nxt    = PH_IDLE;
              res_nxt.done = 1'b1;
              if (q_cmd.store_ok) begin
                frame_seen_nxt   = 1'b0;
                res_nxt.tx_valid = 1'b1;
                res_nxt.bytes[0] = CS_SWITCH_WAIT;
                res_nxt.success  = 1'b1;
              end
            end
          endcase
        end else begin
          // response window ended
          case (phase_r)
            PH_IDENT: begin
              if (frame_seen_r && last_frame_ok_r) begin
                phase_nxt       = PH_PROBE;
                probe_index_nxt = '0;
                part_value_nxt  = '0;
                send_probe      = 1'b1;
              end else begin
                phase_nxt    = PH_IDLE;
                res_nxt.done = 1'b1;
              end
            end
            PH_PROBE: begin
              // silence in the window means the bit is one
              if (!frame_seen_r) begin
                part_value_nxt = part_value_r | (VALUE_W'(1) << pos);
              end
              if (pos == POS_LAST_NEXT) begin
                if (part_sub_r == PART_LAST && part_next_r == PART_LAST) begin
                  part_next_nxt = '0;
                end else begin
                  part_next_nxt = part_next_r + 1'b1;
                end
              end
              send_probe = 1'b1;
              if (probe_index_r == PROBE_LAST) begin
                part_sub_nxt    = part_sub_r + 1'b1;
                probe_index_nxt = '0;
                if (part_sub_r == PART_LAST) begin
                  send_probe       = 1'b0;
                  phase_nxt        = PH_ASSIGN;
                  frame_seen_nxt   = 1'b0;
                  res_nxt.tx_valid = 1'b1;
                  res_nxt.bytes[0] = CS_ASSIGN;
                  res_nxt.bytes[1] = {1'b0, assign_id_r};
                end else begin
                  part_value_nxt = '0;
                end
              end else begin
                probe_index_nxt = probe_index_r + 1'b1;
              end
            end
            default: begin
              phase_nxt    = PH_IDLE;
              res_nxt.done = 1'b1;
            end
          endcase
        end
      end

      if (send_probe) begin
        frame_seen_nxt   = 1'b0;
        res_nxt.tx_valid = 1'b1;
        res_nxt.bytes[0] = CS_IDENTIFY;
        res_nxt.bytes[1] = part_value_nxt[7:0];
        res_nxt.bytes[2] = part_value_nxt[15:8];
        res_nxt.bytes[3] = part_value_nxt[23:16];
        res_nxt.bytes[4] = part_value_nxt[31:24];
        res_nxt.bytes[5] = {3'b000, ~probe_index_nxt};
        res_nxt.bytes[6] = {6'b000000, part_sub_nxt};
        res_nxt.bytes[7] = {6'b000000, part_next_nxt};
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = has_res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      probe_index_r   <= '0;
      part_sub_r      <= '0;
      part_next_r     <= '0;
      part_value_r    <= '0;
      frame_seen_r    <= 1'b0;
      last_frame_ok_r <= 1'b0;
      assign_id_r     <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      phase_r         <= phase_nxt;
      probe_index_r   <= probe_index_nxt;
      part_sub_r      <= part_sub_nxt;
      part_next_r     <= part_next_nxt;
      part_value_r    <= part_value_nxt;
      frame_seen_r    <= frame_seen_nxt;
      last_frame_ok_r <= last_frame_ok_nxt;
      assign_id_r     <= assign_id_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && has_res) begin
      res_r <= res_nxt;
    end
  end

endmodule

>>> rtl/lss_fastscan_master.sv
`timescale 1ns / 1ps
// LSS fastscan master with node-ID assignment. Each input beat is a bus event
// (start, received frame, end of response window); each output beat is a frame
// to send or the final outcome. One beat is taken per clock: the input side
// decodes the event into a small queue, and the sequencer drains one entry per
// cycle into a single output register while it is free or being emptied; a result
// is held in the queue, then in the output register. Throughput drops only while
// that register is stalled and the queue has filled. Frames that produce no result
// (replies inside a window, events while idle) are absorbed without an output beat.
module lss_fastscan_master #(
  parameter int unsigned QUEUE_DEPTH = lfs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata, lowest bit up: new_node_id[6:0], rx_can_id[17:7], rx_byte0[25:18],
  // rx_byte1[33:26], zero fill
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lfs_pkg::IN_DATA_W-1:0]     in_tdata,
  // in_tuser: req_type[1:0]
  input  logic [lfs_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tdata, lowest bit up: tx_b0[7:0] .. tx_b7[63:56]
  output logic [lfs_pkg::OUT_DATA_W-1:0]    out_tdata,
  // out_tuser, lowest bit up: tx_valid, seq_done, seq_success
  output logic [lfs_pkg::OUT_USER_W-1:0]    out_tuser,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [lfs_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);
  import lfs_pkg::*;

  logic [COB_W-1:0] master_cob_id_r;
  logic [COB_W-1:0] slave_cob_id_r;
  logic             cfg_wr;
  logic             reg_sel;

  logic             q_full, q_empty, q_push, q_pop;
  lfs_cmd_t         push_cmd, head_cmd;
  lfs_res_t         res;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (reg_sel == REG_SLAVE_COB) ? {21'd0, slave_cob_id_r}
                                                 : {21'd0, master_cob_id_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_cob_id_r <= MASTER_COB_RST;
      slave_cob_id_r  <= SLAVE_COB_RST;
    end else if (cfg_wr) begin
      if (reg_sel == REG_SLAVE_COB) begin
        slave_cob_id_r <= cfg_pwdata[COB_W-1:0];
      end else begin
        master_cob_id_r <= cfg_pwdata[COB_W-1:0];
      end
    end
  end

  lfs_front u_front (
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .slave_cob_id (slave_cob_id_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  lfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head_cmd (head_cmd)
  );

  lfs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = res.bytes;
  assign out_tuser = {res.success, res.done, res.tx_valid};

endmodule

>>> tb/tb_lss_fastscan_master.sv
`timescale 1ns / 1ps
module tb_lss_fastscan_master;
  import lfs_pkg::*;

  localparam int unsigned IDLE_LIMIT       = 4000;
  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam int unsigned ITEM_TARGET      = 1200;
  localparam int unsigned FULL_SCAN_EVENTS = 400;

  // How the slave side answers an assign or store command
  typedef enum logic [1:0] {
    RPL_GOOD,
    RPL_BAD_CS,
    RPL_BAD_ERR,
    RPL_SILENT
  } reply_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic [IN_USER_W-1:0]  in_tuser    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [31:0]           cfg_pwdata  = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  // Shadow of the sequencer
  logic [COB_W-1:0]   master_cob;
  logic [COB_W-1:0]   slave_cob;
  phase_t             scan_phase;
  logic [PROBE_W-1:0] probe_idx;
  logic [PART_W-1:0]  part_sub;
  logic [PART_W-1:0]  part_next;
  logic [VALUE_W-1:0] part_value;
  logic               frame_seen;
  logic               last_frame_ok;
  logic [NODE_W-1:0]  assign_id;

  lfs_res_t    expected_frames[$];
  int unsigned errors      = 0;
  int unsigned events_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left  = 0;
  bit          gaps_on     = 1'b0;
  bit          stalls_on   = 1'b0;

  always #4 clk = ~clk;

  lss_fastscan_master u_dut (.*);

  function automatic int unsigned pick_idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [COB_W-1:0] rand_cob();
    return COB_W'($urandom_range(0, 2047));
  endfunction

  function automatic logic [NODE_W-1:0] rand_node();
    return NODE_W'($urandom_range(0, 127));
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic reply_t pick_reply();
    if ($urandom_range(0, 9) < 7) return RPL_GOOD;
    return reply_t'($urandom_range(1, 3));
  endfunction

  function automatic lfs_res_t make_frame(logic [7:0] cs, logic [7:0] b1, logic done, logic ok);
    lfs_res_t r;
    r          = '0;
    r.tx_valid = 1'b1;
    r.bytes[0] = cs;
    r.bytes[1] = b1;
    r.done     = done;
    r.success  = ok;
    return r;
  endfunction

  function automatic lfs_res_t probe_frame();
    lfs_res_t r;
    r          = make_frame(CS_IDENTIFY, part_value[7:0], 1'b0, 1'b0);
    r.bytes[2] = part_value[15:8];
    r.bytes[3] = part_value[23:16];
    r.bytes[4] = part_value[31:24];
    r.bytes[5] = 8'(PROBE_LAST - probe_idx);
    r.bytes[6] = 8'(part_sub);
    r.bytes[7] = 8'(part_next);
    return r;
  endfunction

  task automatic reset_model();
    master_cob    = MASTER_COB_RST;
    slave_cob     = SLAVE_COB_RST;
    scan_phase    = PH_IDLE;
    probe_idx     = '0;
    part_sub      = '0;
    part_next     = '0;
    part_value    = '0;
    frame_seen    = 1'b0;
    last_frame_ok = 1'b0;
    assign_id     = '0;
  endtask

  task automatic push_failure();
    lfs_res_t r;
    r      = '0;
    r.done = 1'b1;
    scan_phase = PH_IDLE;
    expected_frames.push_back(r);
  endtask

  task automatic predict_lss_step(req_t kind, logic [NODE_W-1:0] node, logic [COB_W-1:0] rx_id,
                                  logic [7:0] rx_b0, logic [7:0] rx_b1);
    lfs_res_t           r;
    logic [PROBE_W-1:0] pos;
    logic [PART_W-1:0]  was_sub;
    if (kind == REQ_START) begin
      assign_id     = node;
      probe_idx     = '0;
      part_sub      = '0;
      part_next     = '0;
      part_value    = '0;
      last_frame_ok = 1'b0;
      frame_seen    = 1'b0;
      scan_phase    = PH_IDENT;
      r             = make_frame(CS_IDENTIFY, 8'h00, 1'b0, 1'b0);
      r.bytes[5]    = BIT_CHECK_NONE;
      expected_frames.push_back(r);
      return;
    end
    if (kind == REQ_NONE || scan_phase == PH_IDLE) return;

    if (kind == REQ_FRAME) begin
      case (scan_phase)
        PH_IDENT: begin
          frame_seen    = 1'b1;
          last_frame_ok = (rx_id == slave_cob) && (rx_b0 == CS_IDENT_REPLY);
        end
        PH_PROBE: frame_seen = 1'b1;
        PH_ASSIGN: begin
          if (rx_b0 == CS_ASSIGN && rx_b1 == ERR_NONE) begin
            scan_phase = PH_STORE;
            frame_seen = 1'b0;
            expected_frames.push_back(make_frame(CS_STORE, ERR_NONE, 1'b0, 1'b0));
          end else begin
            push_failure();
          end
        end
        default: begin
          if (rx_b0 == CS_STORE && rx_b1 == ERR_NONE) begin
            scan_phase = PH_IDLE;
            frame_seen = 1'b0;
            expected_frames.push_back(make_frame(CS_SWITCH_WAIT, ERR_NONE, 1'b1, 1'b1));
          end else begin
            push_failure();
          end
        end
      endcase
      return;
    end

    // response window closed
    case (scan_phase)
      PH_IDENT: begin
        if (frame_seen && last_frame_ok) begin
          scan_phase = PH_PROBE;
          probe_idx  = '0;
          part_value = '0;
          frame_seen = 1'b0;
          expected_frames.push_back(probe_frame());
        end else begin
          push_failure();
        end
      end
      PH_PROBE: begin
        pos = PROBE_LAST - probe_idx;
        // silence in the window means the probed bit is one
        if (!frame_seen) part_value[pos] = 1'b1;
        if (pos == POS_LAST_NEXT) begin
          if (part_sub == PART_LAST && part_next == PART_LAST) part_next = '0;
          else part_next = part_next + 1'b1;
        end
        if (probe_idx == PROBE_LAST) begin
          was_sub   = part_sub;
          part_sub  = part_sub + 1'b1;
          probe_idx = '0;
          if (was_sub == PART_LAST) begin
            scan_phase = PH_ASSIGN;
            frame_seen = 1'b0;
            expected_frames.push_back(make_frame(CS_ASSIGN, {1'b0, assign_id}, 1'b0, 1'b0));
            return;
          end
          part_value = '0;
        end else begin
          probe_idx = probe_idx + 1'b1;
        end
        frame_seen = 1'b0;
        expected_frames.push_back(probe_frame());
      end
      default: push_failure();
    endcase
  endtask

  task automatic send_event(req_t kind, logic [NODE_W-1:0] node, logic [COB_W-1:0] rx_id,
                            logic [7:0] rx_b0, logic [7:0] rx_b1);
    int unsigned gap;
    gap = gaps_on ? pick_idle_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {6'b0, rx_b1, rx_b0, rx_id, node};
    do @(posedge clk); while (!in_tready);
    predict_lss_step(kind, node, rx_id, rx_b0, rx_b1);
    events_sent++;
  endtask

  task automatic send_noise(req_t kind);
    send_event(kind, rand_node(), rand_cob(), rand_byte(), rand_byte());
  endtask

  // Hold the input until every result is out, then let any absorbed beats settle
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(logic write, logic idx, logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_cob_reg(logic idx);
    logic [31:0] rd;
    logic [31:0] want;
    cfg_access(1'b0, idx, '0, rd);
    want = 32'((idx == REG_MASTER_COB) ? master_cob : slave_cob);
    if (rd !== want) begin
      $error("%s: expected %0d, got %0d",
             (idx == REG_MASTER_COB) ? "master_cob_id" : "slave_cob_id", want, rd);
      errors++;
    end
  endtask

  task automatic program_cob(logic idx, logic [COB_W-1:0] value);
    logic [31:0] rd;
    drain_results();
    cfg_access(1'b1, idx, 32'(value), rd);
    if (idx == REG_MASTER_COB) master_cob = value;
    else slave_cob = value;
    check_cob_reg(idx);
  endtask

  task automatic send_reply(logic [7:0] cs, reply_t mode);
    case (mode)
      RPL_GOOD:    send_event(REQ_FRAME, rand_node(), rand_cob(), cs, ERR_NONE);
      RPL_BAD_CS:  send_event(REQ_FRAME, rand_node(), rand_cob(), cs ^ 8'($urandom_range(1, 255)),
                              $urandom_range(0, 1) ? ERR_NONE : rand_byte());
      RPL_BAD_ERR: send_event(REQ_FRAME, rand_node(), rand_cob(), cs, 8'($urandom_range(1, 255)));
      default:     send_noise(REQ_WEND);
    endcase
  endtask

  // One fastscan run: identify window, probes until the scan leaves the probe phase,
  // then the assign and store answers. abort_after restarts the scan after that many probes.
  task automatic run_fastscan(logic [NODE_W-1:0] node, bit ident_good, int unsigned answer_pct,
                              reply_t assign_reply, reply_t store_reply, int unsigned abort_after);
    int unsigned n_frames;
    int unsigned probes;
    send_event(REQ_START, node, rand_cob(), rand_byte(), rand_byte());
    n_frames = $urandom_range(ident_good ? 1 : 0, 3);
    for (int k = 0; k < n_frames; k++) begin
      if (ident_good && k == n_frames - 1)
        send_event(REQ_FRAME, rand_node(), slave_cob, CS_IDENT_REPLY, rand_byte());
      else
        send_event(REQ_FRAME, rand_node(), $urandom_range(0, 1) ? slave_cob : rand_cob(),
                   $urandom_range(0, 1) ? CS_IDENT_REPLY : rand_byte(), rand_byte());
    end
    send_noise(REQ_WEND);
    probes = 0;
    while (scan_phase == PH_PROBE) begin
      if (abort_after != 0 && probes == abort_after) begin
        send_noise(REQ_START);
        return;
      end
      if ($urandom_range(0, 99) < answer_pct) repeat ($urandom_range(1, 2)) send_noise(REQ_FRAME);
      if ($urandom_range(0, 63) == 0) send_noise(REQ_NONE);
      if ($urandom_range(0, 199) == 0) drain_results();
      send_noise(REQ_WEND);
      probes++;
    end
    if (scan_phase == PH_ASSIGN) send_reply(CS_ASSIGN, assign_reply);
    if (scan_phase == PH_STORE) send_reply(CS_STORE, store_reply);
  endtask

  task automatic test_idle_events();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    send_event(REQ_FRAME, '1, '1, 8'hFF, 8'hFF);
    send_event(REQ_WEND, '0, '0, 8'h00, 8'h00);
    send_event(REQ_NONE, '1, '1, 8'hFF, 8'hFF);
    drain_results();
  endtask

  task automatic test_identify_window();
    // no reply at all, node ID zero latched
    send_event(REQ_START, '0, '0, 8'h00, 8'h00);
    send_event(REQ_WEND, '1, '1, 8'hFF, 8'hFF);
    // good reply overtaken by one from another identifier
    send_event(REQ_START, '1, '1, 8'hFF, 8'hFF);
    send_event(REQ_FRAME, 7'd1, slave_cob, CS_IDENT_REPLY, ERR_NONE);
    send_event(REQ_FRAME, 7'd2, slave_cob ^ 11'h400, CS_IDENT_REPLY, ERR_NONE);
    send_event(REQ_WEND, '0, '0, 8'h00, 8'h00);
    // wrong specifier first, then a good reply: the scan begins
    send_event(REQ_START, 7'd1, '0, 8'h00, 8'h00);
    send_event(REQ_FRAME, '0, slave_cob, CS_IDENT_REPLY ^ 8'h01, 8'hFF);
    send_event(REQ_FRAME, '0, slave_cob, CS_IDENT_REPLY, 8'hFF);
    send_event(REQ_NONE, '1, '1, 8'hFF, 8'hFF);
    send_event(REQ_WEND, '0, '0, 8'h00, 8'h00);
    // one answered probe, one silent
    send_event(REQ_FRAME, '0, '1, 8'hA5, 8'h5A);
    send_event(REQ_WEND, '1, '0, 8'h5A, 8'hA5);
    send_event(REQ_WEND, '0, '1, 8'hFF, 8'h00);
    // restart in the middle of the scan
    send_event(REQ_START, 7'h55, '0, 8'h00, 8'h00);
    send_event(REQ_FRAME, 7'h2A, slave_cob, CS_IDENT_REPLY, ERR_NONE);
    send_event(REQ_WEND, '0, '0, 8'h00, 8'h00);
    drain_results();
  endtask

  task automatic test_cob_registers();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    check_cob_reg(REG_MASTER_COB);
    check_cob_reg(REG_SLAVE_COB);
    program_cob(REG_MASTER_COB, '0);
    program_cob(REG_SLAVE_COB, '0);
    run_fastscan(rand_node(), 1'b1, 50, RPL_GOOD, RPL_GOOD, 3);
    program_cob(REG_MASTER_COB, '1);
    program_cob(REG_SLAVE_COB, '1);
    run_fastscan(rand_node(), 1'b1, 50, RPL_GOOD, RPL_GOOD, 5);
    program_cob(REG_SLAVE_COB, rand_cob());
    run_fastscan(rand_node(), 1'b1, 50, RPL_GOOD, RPL_GOOD, 2);
    drain_results();
  endtask

  task automatic test_reply_outcomes();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    run_fastscan('1, 1'b1, 0, RPL_GOOD, RPL_GOOD, 0);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    run_fastscan('0, 1'b1, 100, RPL_BAD_CS, RPL_GOOD, 0);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    run_fastscan(rand_node(), 1'b1, 10, RPL_SILENT, RPL_GOOD, 0);
    run_fastscan(rand_node(), 1'b1, 10, RPL_GOOD, RPL_BAD_ERR, 0);
    run_fastscan(rand_node(), 1'b1, 10, RPL_GOOD, RPL_SILENT, 0);
    drain_results();
  endtask

  task automatic test_random_traffic();
    int unsigned       pct;
    int unsigned       sel;
    int unsigned       abort_at;
    logic [COB_W-1:0]  cob;
    while (events_sent < ITEM_TARGET) begin
      gaps_on   = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      // keep whole scans out of the tail so the run ends near the item count
      if ($urandom_range(0, 3) == 0 || ITEM_TARGET - events_sent < FULL_SCAN_EVENTS)
        abort_at = $urandom_range(1, 40);
      else
        abort_at = 0;
      case ($urandom_range(0, 9))
        0: begin
          sel = $urandom_range(0, 3);
          cob = (sel == 0) ? '0 : (sel == 1) ? '1 : (sel == 2) ? SLAVE_COB_RST : rand_cob();
          program_cob($urandom_range(0, 1) ? REG_SLAVE_COB : REG_MASTER_COB, cob);
        end
        1: repeat ($urandom_range(4, 20)) send_noise(req_t'($urandom_range(0, 3)));
        2: run_fastscan(rand_node(), 1'b0, 50, pick_reply(), pick_reply(), abort_at);
        default: begin
          sel = $urandom_range(0, 3);
          pct = (sel == 0) ? 0 : (sel == 1) ? 100 : $urandom_range(10, 90);
          run_fastscan(rand_node(), 1'b1, pct, pick_reply(), pick_reply(), abort_at);
        end
      endcase
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      stall_left <= pick_idle_len();
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    lfs_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_frames.size() == 0) begin
        $error("result beat with nothing expected: tdata %h tuser %b", out_tdata, out_tuser);
        errors++;
      end else begin
        want = expected_frames.pop_front();
        check_field("tx_valid", 8'(want.tx_valid), 8'(out_tuser[0]));
        for (int k = 0; k < 8; k++)
          check_field($sformatf("tx_b%0d", k), want.bytes[k], out_tdata[8*k +: 8]);
        check_field("seq_done", 8'(want.done), 8'(out_tuser[1]));
        check_field("seq_success", 8'(want.success), 8'(out_tuser[2]));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_lss_fastscan_master NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reset_model();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_idle_events();
    test_identify_window();
    test_cob_registers();
    test_reply_outcomes();
    test_random_traffic();
    drain_results();
    if (errors == 0) begin
      $display("tb_lss_fastscan_master OK");
    end else begin
      $display("tb_lss_fastscan_master NOT OK");
    end
    $finish;
  end

endmodule

>>> lss_fastscan_master.f
rtl/lfs_pkg.sv
rtl/lfs_front.sv
rtl/lfs_queue.sv
rtl/lfs_back.sv
rtl/lss_fastscan_master.sv
tb/tb_lss_fastscan_master.sv
